// ----- sv/rsi_pkg.sv -----
// Shared constants and types for the ray and sphere intersection unit.
package rsi_pkg;

    // Default widths of coordinates and of their fraction part.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

    // Per-stage control that travels with each word.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_ctl;

endpackage

// ----- sv/rsi_root_div.sv -----
// Back end of the intersection pipeline: bitwise square root, root selection and division.
module rsi_root_div import rsi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_ctl                          i_ctl,
    input  logic [4*COORD_WIDTH+1:0]      i_e,
    input  logic [2*COORD_WIDTH:0]        i_habs,
    input  logic [2*COORD_WIDTH-1:0]      i_a,
    output t_ctl                          o_ctl,
    output logic [COORD_WIDTH-1:0]        o_dist
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int AW  = 2*W;
    localparam int HAW = 2*W + 1;
    localparam int EPW = 4*W + 2;
    localparam int EW  = EPW + 2*F;
    localparam int RW  = EW / 2;
    localparam int RMW = RW + 1;
    localparam int TW  = RW + 3;
    localparam int MW  = RW;
    localparam int DW  = ((MW > AW + W) ? MW : AW + W) + 1;

    // Square root stages: one result bit per stage.
    logic [RMW-1:0] r_rem     [RW+1];
    logic [RW-1:0]  r_root    [RW+1];
    logic [EW-1:0]  r_rad     [RW];
    logic [HAW-1:0] r_sq_habs [RW+1];
    logic [AW-1:0]  r_sq_a    [RW+1];
    logic [RW:0]    r_sq_v;
    logic [RW:0]    r_sq_hit;

    // Load the scaled discriminant into the first root stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]     <= '0;
            r_root[0]    <= '0;
            r_rad[0]     <= EW'(i_e) << (2*F);
            r_sq_habs[0] <= i_habs;
            r_sq_a[0]    <= i_a;
            r_sq_hit[0]  <= i_ctl.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= '0;
        end else if (i_en) begin
            r_sq_v <= {r_sq_v[RW-1:0], i_ctl.valid};
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        logic [TW-1:0] w_t;
        logic [TW-1:0] w_tr;
        logic [TW-1:0] w_d;
        logic          w_ge;

        // Bring down two radicand bits and try the next root bit.
        assign w_t  = {r_rem[j], r_rad[j][EW-1 -: 2]};
        assign w_tr = TW'({r_root[j], 2'b01});
        assign w_ge = (w_t >= w_tr);
        assign w_d  = w_t - w_tr;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]     <= w_ge ? w_d[RMW-1:0] : w_t[RMW-1:0];
                r_root[j+1]    <= {r_root[j][RW-2:0], w_ge};
                r_sq_habs[j+1] <= r_sq_habs[j];
                r_sq_a[j+1]    <= r_sq_a[j];
                r_sq_hit[j+1]  <= r_sq_hit[j];
            end
        end

        if (j < RW - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[j+1] <= r_rad[j] << 2;
                end
            end
        end
    end

    // Numerator of the smaller root, rounded so that the floor comes out exact.
    logic [MW-1:0] w_m;
    logic [MW-1:0] r_m;
    logic [AW-1:0] r_m_a;
    logic          r_m_v;
    logic          r_m_hit;

    assign w_m = {r_sq_habs[RW], {F{1'b0}}} - r_root[RW] - MW'(r_rem[RW] != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m     <= w_m;
            r_m_a   <= r_sq_a[RW];
            r_m_hit <= r_sq_hit[RW];
        end
    end

    // Division stages: saturation check, then one quotient bit per stage.
    logic [DW-1:0] r_pr  [W];
    logic [AW-1:0] r_da  [W];
    logic [W-1:0]  r_q   [1:W];
    logic [W:0]    r_dsat;
    logic [W:0]    r_dhit;
    logic [W:0]    r_dv;
    logic          w_sat;

    assign w_sat = (DW'(r_m) >= (DW'(r_m_a) << W));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr[0]   <= DW'(r_m);
            r_da[0]   <= r_m_a;
            r_dsat[0] <= w_sat;
            r_dhit[0] <= r_m_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_dv  <= '0;
        end else if (i_en) begin
            r_m_v <= r_sq_v[RW];
            r_dv  <= {r_dv[W-1:0], r_m_v};
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_div
        logic [DW-1:0] w_tr;
        logic          w_ge;

        assign w_tr = DW'(r_da[k]) << (W - 1 - k);
        assign w_ge = (r_pr[k] >= w_tr);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dsat[k+1] <= r_dsat[k];
                r_dhit[k+1] <= r_dhit[k];
            end
        end

        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[1] <= {{(W-1){1'b0}}, w_ge};
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[k+1] <= {r_q[k][W-2:0], w_ge};
                end
            end
        end

        if (k < W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pr[k+1] <= w_ge ? (r_pr[k] - w_tr) : r_pr[k];
                    r_da[k+1] <= r_da[k];
                end
            end
        end
    end

    // Final selection: zero on a miss, all ones when the distance overflows.
    logic          r_o_v;
    logic          r_o_hit;
    logic [W-1:0]  r_o_dist;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_hit  <= r_dhit[W];
            r_o_dist <= !r_dhit[W] ? '0 : (r_dsat[W] ? '1 : r_q[W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_dv[W];
        end
    end

    assign o_ctl  = '{valid: r_o_v, hit: r_o_hit};
    assign o_dist = r_o_dist;

endmodule

// ----- sv/ray_sphere_intersect_unit.sv -----
// Top level of the ray and sphere intersection unit: configuration, front end and output stage.
//
// Tests one ray per word against a sphere set through the configuration port and
// returns a hit flag and the nearest non-negative distance in Q16.16, saturating
// at all ones; a miss returns zero. The unit is fully pipelined and accepts one
// word every cycle while its skid stage is empty. Eight front stages form the
// quadratic and its discriminant, then the square root takes one stage per root
// bit and the division one stage per distance bit. An output register with a
// one-word skid stage lets the unit take one more word while a result waits.
// The user must write configuration only while the unit is idle; the unit
// itself does not enforce this.
module ray_sphere_intersect_unit import rsi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic        [COORD_WIDTH-1:0] o_distance,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [COORD_WIDTH-1:0] i_cfg_data
);

    localparam int W       = COORD_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int QW      = W + 1;
    localparam int AW      = 2*W;
    localparam int HW      = 2*W + 2;
    localparam int CW      = 2*W + 3;
    localparam int HAW     = 2*W + 1;
    localparam int CAW     = 2*W + 2;
    localparam int L       = W + 1;
    localparam int EPW     = 4*W + 2;
    localparam int N_FRONT = 8;
    localparam logic [W-2:0] RADIUS_ONE = (W-1)'(1) << F;

    // Configuration registers.
    logic signed [W-1:0] r_center [3];
    logic        [W-2:0] r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_radius    <= RADIUS_ONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                CFG_RADIUS:   r_radius    <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the skid stage is empty.
    logic r_skid_v;
    logic w_en;
    logic w_acc;

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;

    logic [N_FRONT-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[N_FRONT-2:0], w_acc};
        end
    end

    // Front stage registers.
    logic signed [W-1:0]    r_s1_o [3];
    logic signed [W-1:0]    r_s1_d [3];
    logic signed [QW-1:0]   r_s2_q [3];
    logic signed [W-1:0]    r_s2_d [3];
    logic signed [2*W-1:0]  r_s3_dd [3];
    logic signed [2*W:0]    r_s3_qd [3];
    logic signed [2*W:0]    r_s3_qq [3];
    logic        [2*W-3:0]  r_s3_rr;
    logic        [AW-1:0]   r_s4_a;
    logic signed [HW-1:0]   r_s4_h;
    logic signed [CW-1:0]   r_s4_c;
    logic        [AW-1:0]   r_s5_a;
    logic        [HAW-1:0]  r_s5_habs;
    logic        [CAW-1:0]  r_s5_cabs;
    logic                   r_s5_miss;
    logic        [2*W-1:0]  r_s6_hh;
    logic        [2*W:0]    r_s6_hhl;
    logic        [2*W+1:0]  r_s6_hll;
    logic        [2*W-1:0]  r_s6_ahch;
    logic        [2*W-1:0]  r_s6_ahcl;
    logic        [2*W+1:0]  r_s6_alch;
    logic        [2*W+1:0]  r_s6_alcl;
    logic        [AW-1:0]   r_s6_a;
    logic        [HAW-1:0]  r_s6_habs;
    logic                   r_s6_miss;
    logic        [EPW-1:0]  r_s7_h2;
    logic        [EPW-1:0]  r_s7_ac;
    logic        [AW-1:0]   r_s7_a;
    logic        [HAW-1:0]  r_s7_habs;
    logic                   r_s7_miss;
    logic        [EPW-1:0]  r_s8_e;
    logic        [AW-1:0]   r_s8_a;
    logic        [HAW-1:0]  r_s8_habs;
    logic                   r_s8_hit;

    // Next values of the front stages.
    logic signed [QW-1:0]   n_q [3];
    logic signed [2*W-1:0]  n_dd [3];
    logic signed [2*W:0]    n_qd [3];
    logic signed [2*W:0]    n_qq [3];
    logic        [2*W-3:0]  n_rr;
    logic        [AW-1:0]   n_a;
    logic signed [HW-1:0]   n_h;
    logic signed [CW-1:0]   n_c;
    logic        [HW-1:0]   n_hneg;
    logic        [HAW-1:0]  n_habs;
    logic        [CAW-1:0]  n_cabs;
    logic                   n_miss;
    logic        [W-1:0]    n_hh;
    logic        [L-1:0]    n_hl;
    logic        [W-2:0]    n_ah;
    logic        [L-1:0]    n_al;
    logic        [W:0]      n_ch;
    logic        [L-1:0]    n_cl;
    logic        [EPW-1:0]  n_h2;
    logic        [EPW-1:0]  n_ac;
    logic        [EPW:0]    n_e;
    logic                   n_hit;

    always_comb begin
        // Offset from the center, then the nine coordinate products.
        for (int k = 0; k < 3; k++) begin
            n_q[k]  = QW'(r_s1_o[k]) - QW'(r_center[k]);
            n_dd[k] = r_s2_d[k] * r_s2_d[k];
            n_qd[k] = r_s2_q[k] * r_s2_d[k];
            n_qq[k] = r_s2_q[k] * r_s2_q[k];
        end
        n_rr = r_radius * r_radius;

        // Quadratic coefficients a, half b and c.
        n_a = $unsigned(r_s3_dd[0]) + $unsigned(r_s3_dd[1]) + $unsigned(r_s3_dd[2]);
        n_h = HW'(r_s3_qd[0]) + HW'(r_s3_qd[1]) + HW'(r_s3_qd[2]);
        n_c = CW'(r_s3_qq[0]) + CW'(r_s3_qq[1]) + CW'(r_s3_qq[2]) - CW'(r_s3_rr);

        // Magnitudes and the early miss cases.
        n_hneg = -r_s4_h;
        n_habs = r_s4_h[HW-1] ? n_hneg[HAW-1:0] : '0;
        n_cabs = r_s4_c[CW-1] ? '0 : r_s4_c[CAW-1:0];
        n_miss = (r_s4_a == '0) || r_s4_c[CW-1] || (!r_s4_h[HW-1] && (r_s4_h != '0));

        // Split the wide operands into halves for the partial products.
        n_hh = r_s5_habs[HAW-1:L];
        n_hl = r_s5_habs[L-1:0];
        n_ah = r_s5_a[AW-1:L];
        n_al = r_s5_a[L-1:0];
        n_ch = r_s5_cabs[CAW-1:L];
        n_cl = r_s5_cabs[L-1:0];

        // Recombine the partial products into h*h and a*c.
        n_h2 = (EPW'(r_s6_hh) << (2*L)) + (EPW'(r_s6_hhl) << (L+1)) + EPW'(r_s6_hll);
        n_ac = (EPW'(r_s6_ahch) << (2*L)) + (EPW'(r_s6_ahcl) << L)
             + (EPW'(r_s6_alch) << L) + EPW'(r_s6_alcl);

        // Quarter discriminant and the final hit decision.
        n_e   = {1'b0, r_s7_h2} - {1'b0, r_s7_ac};
        n_hit = !r_s7_miss && !n_e[EPW];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_o[0] <= i_origin_x;
            r_s1_o[1] <= i_origin_y;
            r_s1_o[2] <= i_origin_z;
            r_s1_d[0] <= i_dir_x;
            r_s1_d[1] <= i_dir_y;
            r_s1_d[2] <= i_dir_z;
            for (int k = 0; k < 3; k++) begin
                r_s2_q[k]  <= n_q[k];
                r_s2_d[k]  <= r_s1_d[k];
                r_s3_dd[k] <= n_dd[k];
                r_s3_qd[k] <= n_qd[k];
                r_s3_qq[k] <= n_qq[k];
            end
            r_s3_rr   <= n_rr;
            r_s4_a    <= n_a;
            r_s4_h    <= n_h;
            r_s4_c    <= n_c;
            r_s5_a    <= r_s4_a;
            r_s5_habs <= n_habs;
            r_s5_cabs <= n_cabs;
            r_s5_miss <= n_miss;
            r_s6_hh   <= n_hh * n_hh;
            r_s6_hhl  <= n_hh * n_hl;
            r_s6_hll  <= n_hl * n_hl;
            r_s6_ahch <= n_ah * n_ch;
            r_s6_ahcl <= n_ah * n_cl;
            r_s6_alch <= n_al * n_ch;
            r_s6_alcl <= n_al * n_cl;
            r_s6_a    <= r_s5_a;
            r_s6_habs <= r_s5_habs;
            r_s6_miss <= r_s5_miss;
            r_s7_h2   <= n_h2;
            r_s7_ac   <= n_ac;
            r_s7_a    <= r_s6_a;
            r_s7_habs <= r_s6_habs;
            r_s7_miss <= r_s6_miss;
            r_s8_e    <= n_hit ? n_e[EPW-1:0] : '0;
            r_s8_a    <= r_s7_a;
            r_s8_habs <= r_s7_habs;
            r_s8_hit  <= n_hit;
        end
    end

    // Square root and division back end.
    t_ctl         w_core_ctl;
    logic [W-1:0] w_core_dist;

    rsi_root_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   ('{valid: r_v[N_FRONT-1], hit: r_s8_hit}),
        .i_e     (r_s8_e),
        .i_habs  (r_s8_habs),
        .i_a     (r_s8_a),
        .o_ctl   (w_core_ctl),
        .o_dist  (w_core_dist)
    );

    // Output register with a one-word skid stage.
    logic         r_out_v;
    logic         r_out_hit;
    logic [W-1:0] r_out_dist;
    logic         r_skid_hit;
    logic [W-1:0] r_skid_dist;
    logic         w_out_free;

    assign w_out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_v <= w_core_ctl.valid;
        end else if (w_core_ctl.valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_out_free) begin
                r_out_hit  <= r_skid_hit;
                r_out_dist <= r_skid_dist;
            end
        end else if (w_out_free) begin
            r_out_hit  <= w_core_ctl.hit;
            r_out_dist <= w_core_dist;
        end else begin
            r_skid_hit  <= w_core_ctl.hit;
            r_skid_dist <= w_core_dist;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_hit       = r_out_hit;
    assign o_distance  = r_out_dist;

endmodule

// ----- sv/rsi_checker.sv -----
// Port-level checks for the ray and sphere intersection unit, bound to its top level.
module rsi_checker import rsi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic                   o_hit,
    input logic [COORD_WIDTH-1:0] o_distance
);

    // A result word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_hit) && $stable(o_distance))
        else $error("stalled result word changed");

    // A miss always reports a zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_distance == '0)
        else $error("miss with a nonzero distance");

    // The input side only blocks while a result word is waiting.
    a_block_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input blocked with no result pending");

    // Input ready drops only after a stalled output.
    a_block_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input blocked without an output stall");

endmodule

bind ray_sphere_intersect_unit rsi_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_rsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_hit       (o_hit),
    .o_distance  (o_distance)
);
